FILE: sv/tcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types and constants of the time code pulse decoder.
// ----------------------------------------------------------------------------
package tcpd_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    CfgPowered        = 3'd0,
    CfgZeroMin        = 3'd1,
    CfgZeroMax        = 3'd2,
    CfgOneMin         = 3'd3,
    CfgOneMax         = 3'd4,
    CfgSampleInterval = 3'd5,
    CfgMinuteGap      = 3'd6,
    CfgDebounceMax    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 12;

  typedef struct packed {
    logic        powered;
    logic [9:0]  zero_min;
    logic [9:0]  zero_max;
    logic [9:0]  one_min;
    logic [9:0]  one_max;
    logic [7:0]  sample_interval;
    logic [11:0] minute_gap;
    logic [2:0]  debounce_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    powered:         1'b0,
    zero_min:        10'd55,
    zero_max:        10'd120,
    one_min:         10'd155,
    one_max:         10'd220,
    sample_interval: 8'd2,
    minute_gap:      12'd1500,
    debounce_max:    3'd2
  };

  // what the front end saw on one poll
  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvOff  = 2'd1,
    EvFall = 2'd2,
    EvRise = 2'd3
  } ev_kind_e;

  // pulse classes
  localparam logic [1:0] ClsZero = 2'd0;
  localparam logic [1:0] ClsOne  = 2'd1;
  localparam logic [1:0] ClsBad  = 2'd2;
  localparam logic [1:0] ClsNone = 2'd3;

  // bit position codes
  localparam logic [6:0] PosNotSynced  = 7'h7f;
  localparam logic [6:0] PosMax        = 7'd63;
  localparam logic [6:0] PosLastStored = 7'd59;
  localparam logic [6:0] PosFrameShort = 7'd58;
  localparam logic [6:0] PosFrameLong  = 7'd59;

  // one result, last member in the lowest bits
  typedef struct packed {
    logic [7:0] year_value;
    logic [4:0] month_value;
    logic [5:0] day_value;
    logic [5:0] hour_value;
    logic [6:0] minute_value;
    logic       frame_ok;
    logic       minute_mark;
    logic [1:0] bit_class;
    logic       edge_detected;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

endpackage

FILE: sv/time_code_pulse_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_code_pulse_decoder
// Minute frame decoder for a pulse width time code receiver.
//
//   port group   dir  fields (lsb first)
//   s_axis       in   tdata: time_ms[31:0], pin_level[32]
//   m_axis       out  tdata: edge_detected, bit_class, minute_mark, frame_ok,
//                            minute, hour, day, month, year values
//   cfg          in   we, addr (register index), wdata[11:0]
//
// One poll per cycle is accepted while the queue is not full. Each poll is
// queued, then its result is registered when the back end takes it and
// leaves at the first edge with the output side ready. The front end keeps
// the debounce state and the back end the frame state; a two-entry queue
// lets either side stall, so input stalls once the result register and both
// queue entries are held. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module time_code_pulse_decoder #(
  parameter int unsigned TimeWidth = 32,
  parameter int unsigned FrameBits = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [39:0]                         s_axis_tdata_i,  // time_ms, pin_level
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // edge_detected, bit_class, minute_mark, frame_ok, minute_value, hour_value,
  // day_value, month_value, year_value
  output logic [39:0]                         m_axis_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [tcpd_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [tcpd_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import tcpd_pkg::*;

  localparam int unsigned EvWidth = TimeWidth + 2;

  cfg_t                 cfg_q;
  logic                 q_full, q_push, q_pop, q_valid;
  ev_kind_e             f_kind;
  logic [TimeWidth-1:0] f_time;
  logic [EvWidth-1:0]   q_rdata;
  result_t              result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgPowered:        cfg_q.powered         <= cfg_wdata_i[0];
        CfgZeroMin:        cfg_q.zero_min        <= cfg_wdata_i[9:0];
        CfgZeroMax:        cfg_q.zero_max        <= cfg_wdata_i[9:0];
        CfgOneMin:         cfg_q.one_min         <= cfg_wdata_i[9:0];
        CfgOneMax:         cfg_q.one_max         <= cfg_wdata_i[9:0];
        CfgSampleInterval: cfg_q.sample_interval <= cfg_wdata_i[7:0];
        CfgMinuteGap:      cfg_q.minute_gap      <= cfg_wdata_i[11:0];
        CfgDebounceMax:    cfg_q.debounce_max    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  tcpd_front #(
    .TimeWidth (TimeWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .time_ms_i   (s_axis_tdata_i[31:0]),
    .pin_level_i (s_axis_tdata_i[32]),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .ev_kind_o   (f_kind),
    .ev_time_o   (f_time)
  );

  tcpd_fifo #(
    .Width (EvWidth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_kind, f_time}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  tcpd_back #(
    .TimeWidth (TimeWidth),
    .FrameBits (FrameBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (q_valid),
    .ev_kind_i   (ev_kind_e'(q_rdata[EvWidth-1:TimeWidth])),
    .ev_time_i   (q_rdata[TimeWidth-1:0]),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {(40 - ResultWidth)'(0), result};

`ifndef SYNTHESIS
  a_ok_needs_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && result.frame_ok |-> result.minute_mark)
    else $error("frame_ok without minute mark");

  a_class_needs_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (result.bit_class != ClsNone) |-> result.edge_detected)
    else $error("pulse class without falling edge");

  a_no_mark_no_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !result.minute_mark |->
      (result.minute_value == 7'd0) && (result.year_value == 8'd0) &&
      (result.day_value == 6'd0))
    else $error("decoded values without minute mark");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid_o)
    else $error("queue popped but no result shown");
`endif

endmodule

FILE: sv/tcpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_front
// Poll sampling, debounce and line edge detection.
// ----------------------------------------------------------------------------
module tcpd_front #(
  parameter int unsigned TimeWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcpd_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           time_ms_i,
  input  logic                  pin_level_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output tcpd_pkg::ev_kind_e    ev_kind_o,
  output logic [TimeWidth-1:0]  ev_time_o
);
  import tcpd_pkg::*;

  logic [TimeWidth-1:0] last_q, last_d, t, elapsed;
  logic [2:0]           cnt_q, cnt_d;
  logic                 line_q, line_d, prev_q, prev_d;
  logic                 taken;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign t          = TimeWidth'(time_ms_i);
  assign elapsed    = t - last_q;
  assign taken      = cfg_i.powered && (elapsed > TimeWidth'(cfg_i.sample_interval));
  assign ev_time_o  = t;

  always_comb begin
    last_d    = last_q;
    cnt_d     = cnt_q;
    line_d    = line_q;
    prev_d    = prev_q;
    ev_kind_o = EvNone;
    if (!cfg_i.powered) begin
      ev_kind_o = EvOff;
    end else if (taken) begin
      last_d = t;
      if (pin_level_i) begin
        if (cnt_q < cfg_i.debounce_max) cnt_d = cnt_q + 3'd1;
        else line_d = 1'b1;
      end else begin
        if (cnt_q != 3'd0) cnt_d = cnt_q - 3'd1;
        else line_d = 1'b0;
      end
      if (!line_d && prev_q) ev_kind_o = EvFall;
      else if (line_d && !prev_q) ev_kind_o = EvRise;
      prev_d = line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      cnt_q  <= '0;
      line_q <= 1'b0;
      prev_q <= 1'b0;
    end else if (push_o) begin
      last_q <= last_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
      prev_q <= prev_d;
    end
  end

endmodule

FILE: sv/tcpd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module tcpd_fifo #(
  parameter int unsigned Width = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/tcpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_back
// Pulse timing, bit storage, frame decode and the result register.
// ----------------------------------------------------------------------------
module tcpd_back #(
  parameter int unsigned TimeWidth = 32,
  parameter int unsigned FrameBits = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcpd_pkg::cfg_t        cfg_i,
  input  logic                  ev_valid_i,
  input  tcpd_pkg::ev_kind_e    ev_kind_i,
  input  logic [TimeWidth-1:0]  ev_time_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tcpd_pkg::result_t     result_o
);
  import tcpd_pkg::*;

  localparam int unsigned PosIdxW = $clog2(FrameBits);

  function automatic logic [7:0] times10(input logic [3:0] d);
    return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
  endfunction

  logic [TimeWidth-1:0] start_q, start_d, end_q, end_d, width, gap;
  logic [6:0]           pos_q, pos_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic [7:0]           mi, hr, dy, mo, yr;
  logic                 par_ok, range_ok;
  logic [1:0]           cls;

  assign pop_o       = ev_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign width       = ev_time_i - start_q;
  assign gap         = ev_time_i - end_q;

  // frame decode
  assign mi = 8'(frame_q[24:21]) + times10({1'b0, frame_q[27:25]});
  assign hr = 8'(frame_q[32:29]) + times10({2'b00, frame_q[34:33]});
  assign dy = 8'(frame_q[39:36]) + times10({2'b00, frame_q[41:40]});
  assign mo = 8'(frame_q[48:45]) + times10({3'b000, frame_q[49]});
  assign yr = 8'(frame_q[53:50]) + times10(frame_q[57:54]);
  assign par_ok = !(^frame_q[28:21]) && !(^frame_q[35:29]) && !(^frame_q[58:36]);
  assign range_ok = (mi <= 8'd59) && (hr <= 8'd23) && (dy >= 8'd1) && (dy <= 8'd31)
                    && (mo >= 8'd1) && (mo <= 8'd12);

  always_comb begin
    if (width >= TimeWidth'(cfg_i.zero_min) && width <= TimeWidth'(cfg_i.zero_max)) begin
      cls = ClsZero;
    end else if (width >= TimeWidth'(cfg_i.one_min) &&
                 width <= TimeWidth'(cfg_i.one_max)) begin
      cls = ClsOne;
    end else begin
      cls = ClsBad;
    end
  end

  always_comb begin
    start_d         = start_q;
    end_d           = end_q;
    pos_d           = pos_q;
    frame_d         = frame_q;
    res_d           = '0;
    res_d.bit_class = ClsNone;
    unique case (ev_kind_i)
      EvNone: ;
      EvOff: res_d.edge_detected = 1'b1;
      EvFall: begin
        res_d.edge_detected = 1'b1;
        res_d.bit_class     = cls;
        end_d               = ev_time_i;
        if (cls == ClsBad) begin
          pos_d = PosNotSynced;
        end else if (pos_q <= PosLastStored && cls == ClsOne) begin
          frame_d[pos_q[PosIdxW-1:0]] = 1'b1;
        end
      end
      EvRise: begin
        start_d = ev_time_i;
        if (gap > TimeWidth'(cfg_i.minute_gap)) begin
          if (pos_q == PosFrameShort || pos_q == PosFrameLong) begin
            res_d.minute_mark  = 1'b1;
            res_d.frame_ok     = par_ok && range_ok;
            res_d.minute_value = mi[6:0];
            res_d.hour_value   = hr[5:0];
            res_d.day_value    = dy[5:0];
            res_d.month_value  = mo[4:0];
            res_d.year_value   = yr;
          end
          pos_d   = '0;
          frame_d = '0;
        end else if (pos_q < PosMax) begin
          pos_d = pos_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '0;
      pos_q       <= PosNotSynced;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        start_q     <= start_d;
        end_q       <= end_d;
        pos_q       <= pos_d;
        frame_q     <= frame_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

endmodule
